// ===== design/lpg_pkg.sv =====
// shared types, widths and codes for the line pixel generator
`default_nettype none

package lpg_pkg;

    // coordinate and derived widths
    localparam int COORD_BITS = 12;
    localparam int DIM_W      = COORD_BITS + 1;
    localparam int ERR_W      = COORD_BITS + 2;
    localparam int COLOR_W    = 8;
    localparam int STATUS_W   = 2;

    // stream payload widths
    localparam int IN_DATA_W    = 4 * COORD_BITS + 3 * COLOR_W;
    localparam int IN_TDATA_W   = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = 3 * COORD_BITS + 3 * COLOR_W;
    localparam int OUT_TDATA_W  = ((OUT_DATA_W + 7) / 8) * 8;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // reset image size
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1 << COORD_BITS);

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_PIXEL  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd2;

    // input tdata layout, lowest field last
    typedef struct packed {
        logic [COLOR_W-1:0]    blue_in;
        logic [COLOR_W-1:0]    green_in;
        logic [COLOR_W-1:0]    red_in;
        logic [COORD_BITS-1:0] end_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] start_x;
    } lpg_in_data_t;

    // one input item
    typedef struct packed {
        logic         action;
        lpg_in_data_t data;
    } lpg_item_t;

    // output tdata layout, lowest field last
    typedef struct packed {
        logic [COORD_BITS-1:0] length;
        logic [COLOR_W-1:0]    blue_out;
        logic [COLOR_W-1:0]    green_out;
        logic [COLOR_W-1:0]    red_out;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COORD_BITS-1:0] pixel_x;
    } lpg_out_data_t;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                last;
        lpg_out_data_t       data;
    } lpg_result_t;

    // handshake between the stages
    typedef struct packed {
        logic valid;
        logic ready;
    } lpg_hs_t;

endpackage

`default_nettype wire

// ===== design/lpg_in_stage.sv =====
// input register stage of the line pixel generator
`default_nettype none

module lpg_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire lpg_pkg::lpg_item_t s_item,
    output lpg_pkg::lpg_hs_t       hs_out,   // valid from here, ready from downstream
    input  wire logic              down_ready,
    output lpg_pkg::lpg_item_t     item_out
);
    import lpg_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lpg_item_t item_reg;
    logic      advance;

    // stage empties when downstream takes the item
    assign advance  = valid_reg && down_ready;
    assign s_tready = !valid_reg || down_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign hs_out.valid = valid_reg;
    assign hs_out.ready = down_ready;
    assign item_out     = item_reg;

endmodule

`default_nettype wire

// ===== design/lpg_core.sv =====
// line state, bounds registers and one Bresenham step per step item
`default_nettype none

module lpg_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_index,
    input  wire logic [lpg_pkg::DIM_W-1:0] cfg_data,
    input  wire lpg_pkg::lpg_hs_t          hs_in,
    input  wire lpg_pkg::lpg_item_t        item,
    output lpg_pkg::lpg_result_t           result
);
    import lpg_pkg::*;

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // line state
    logic [COORD_BITS-1:0]   cur_x_reg,  cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg,  cur_y_next;
    logic [COORD_BITS-1:0]   goal_x_reg, goal_x_next;
    logic [COORD_BITS-1:0]   goal_y_reg, goal_y_next;
    logic [COORD_BITS-1:0]   dx_reg,     dx_next;
    logic [DIM_W-1:0]        ndy_reg,    ndy_next;
    logic                    sxn_reg,    sxn_next;
    logic                    syn_reg,    syn_next;
    logic signed [ERR_W-1:0] err_reg,    err_next;
    logic [3*COLOR_W-1:0]    col_reg,    col_next;
    logic [COORD_BITS-1:0]   cnt_reg,    cnt_next;
    logic                    act_reg,    act_next;

    logic                    fire;
    logic                    reject;
    logic                    x_lt;
    logic                    y_lt;
    logic [COORD_BITS-1:0]   ady;
    logic signed [ERR_W:0]   e2;
    logic signed [ERR_W:0]   ndy_ext;
    logic signed [ERR_W:0]   dx_ext;
    logic                    move_x;
    logic                    move_y;
    logic signed [ERR_W-1:0] add_x;
    logic signed [ERR_W-1:0] add_y;
    logic                    done;

    assign fire = hs_in.valid && hs_in.ready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // load-side terms
    assign reject = ({1'b0, item.data.start_x} >= width_reg)
                 || ({1'b0, item.data.end_x}   >= width_reg)
                 || ({1'b0, item.data.start_y} >= height_reg)
                 || ({1'b0, item.data.end_y}   >= height_reg);
    assign x_lt = item.data.start_x < item.data.end_x;
    assign y_lt = item.data.start_y < item.data.end_y;
    assign ady  = y_lt ? (item.data.end_y - item.data.start_y)
                       : (item.data.start_y - item.data.end_y);

    // step-side terms: doubled error against both deltas
    assign e2      = $signed({err_reg, 1'b0});
    assign ndy_ext = $signed({{(ERR_W + 1 - DIM_W){ndy_reg[DIM_W-1]}}, ndy_reg});
    assign dx_ext  = $signed({{(ERR_W + 1 - COORD_BITS){1'b0}}, dx_reg});
    assign move_x  = e2 >= ndy_ext;
    assign move_y  = e2 <= dx_ext;
    assign add_x   = move_x ? $signed({{(ERR_W - DIM_W){ndy_reg[DIM_W-1]}}, ndy_reg})
                            : ERR_W'(0);
    assign add_y   = move_y ? $signed({{(ERR_W - COORD_BITS){1'b0}}, dx_reg})
                            : ERR_W'(0);

    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        dx_next     = dx_reg;
        ndy_next    = ndy_reg;
        sxn_next    = sxn_reg;
        syn_next    = syn_reg;
        err_next    = err_reg;
        col_next    = col_reg;
        cnt_next    = cnt_reg;
        act_next    = act_reg;
        done        = 1'b0;
        result      = '0;

        if (item.action == ACT_LOAD) begin
            if (reject) begin
                // out of bounds: drop any line in flight
                act_next      = 1'b0;
                result.status = ST_REJECT;
                result.last   = 1'b1;
            end else begin
                cur_x_next  = item.data.start_x;
                cur_y_next  = item.data.start_y;
                goal_x_next = item.data.end_x;
                goal_y_next = item.data.end_y;
                dx_next     = x_lt ? (item.data.end_x - item.data.start_x)
                                   : (item.data.start_x - item.data.end_x);
                ndy_next    = DIM_W'(0) - {1'b0, ady};
                sxn_next    = !x_lt;
                syn_next    = !y_lt;
                err_next    = $signed({{(ERR_W - COORD_BITS){1'b0}}, dx_next})
                            + $signed({{(ERR_W - DIM_W){ndy_next[DIM_W-1]}}, ndy_next});
                col_next    = {item.data.red_in, item.data.green_in, item.data.blue_in};
                cnt_next    = '0;
                done        = (item.data.start_x == item.data.end_x)
                           && (item.data.start_y == item.data.end_y);
                act_next    = !done;
                result.status         = ST_PIXEL;
                result.last           = done;
                result.data.pixel_x   = item.data.start_x;
                result.data.pixel_y   = item.data.start_y;
                result.data.red_out   = item.data.red_in;
                result.data.green_out = item.data.green_in;
                result.data.blue_out  = item.data.blue_in;
            end
        end else if (!act_reg) begin
            result.status = ST_IDLE;
        end else begin
            // one pixel step
            cnt_next = cnt_reg + 1'b1;
            err_next = err_reg + add_x + add_y;
            if (move_x) begin
                cur_x_next = sxn_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
            end
            if (move_y) begin
                cur_y_next = syn_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
            end
            done = (cur_x_next == goal_x_reg) && (cur_y_next == goal_y_reg);
            if (done) begin
                act_next = 1'b0;
            end
            result.status         = ST_PIXEL;
            result.last           = done;
            result.data.pixel_x   = cur_x_next;
            result.data.pixel_y   = cur_y_next;
            result.data.red_out   = col_reg[3*COLOR_W-1:2*COLOR_W];
            result.data.green_out = col_reg[2*COLOR_W-1:COLOR_W];
            result.data.blue_out  = col_reg[COLOR_W-1:0];
            result.data.length    = cnt_next;
        end
    end

    // state update on each item that moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            dx_reg     <= '0;
            ndy_reg    <= '0;
            sxn_reg    <= 1'b0;
            syn_reg    <= 1'b0;
            err_reg    <= '0;
            col_reg    <= '0;
            cnt_reg    <= '0;
            act_reg    <= 1'b0;
        end else if (fire) begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            dx_reg     <= dx_next;
            ndy_reg    <= ndy_next;
            sxn_reg    <= sxn_next;
            syn_reg    <= syn_next;
            err_reg    <= err_next;
            col_reg    <= col_next;
            cnt_reg    <= cnt_next;
            act_reg    <= act_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lpg_out_stage.sv =====
// result register stage of the line pixel generator
`default_nettype none

module lpg_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lpg_pkg::lpg_hs_t     hs_in,
    input  wire lpg_pkg::lpg_result_t result,
    output logic                      up_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output lpg_pkg::lpg_result_t      m_result
);
    import lpg_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    lpg_result_t result_reg;
    logic        fire;

    // free when empty or being drained
    assign up_ready = !valid_reg || m_tready;
    assign fire     = hs_in.valid && hs_in.ready;

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// ===== design/line_pixel_generator_unit.sv =====
// An accepted item passes the input register, the combinational core and the result register.
// One item per cycle unless the result side stalls; the step loop is one add-compare pass on the line registers.
// A waiting result stalls the input side once the input register is full as well.
// Reset: synchronous, active-low aresetn clears both stages and the line state (no active line)
// and sets image width and height to 4096.
`default_nettype none

module line_pixel_generator_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [lpg_pkg::DIM_W-1:0]       cfg_data,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, end_x, end_y, red_in, green_in, blue_in
    input  wire logic [lpg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action
    input  wire logic                            s_tuser,
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pixel_x, pixel_y, red_out, green_out, blue_out, length, zero pad
    output logic [lpg_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // status
    output logic [lpg_pkg::STATUS_W-1:0]         m_tuser,
    output logic                                 m_tlast
);
    import lpg_pkg::*;

    lpg_item_t   s_item;
    lpg_item_t   item;
    lpg_hs_t     hs;
    lpg_result_t result;
    lpg_result_t m_result;
    logic        out_ready;

    assign cfg_ready   = 1'b1;
    assign s_item.action = s_tuser;
    assign s_item.data   = lpg_in_data_t'(s_tdata[IN_DATA_W-1:0]);

    lpg_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .hs_out     (hs),
        .down_ready (out_ready),
        .item_out   (item)
    );

    lpg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hs_in     (hs),
        .item      (item),
        .result    (result)
    );

    lpg_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .hs_in    (hs),
        .result   (result),
        .up_ready (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    // result packing
    assign m_tdata = OUT_TDATA_W'(m_result.data);
    assign m_tuser = m_result.status;
    assign m_tlast = m_result.last;

endmodule

`default_nettype wire

// ===== design/lpg_checker.sv =====
// port-level checks for the line pixel generator, bound to the top level
`default_nettype none

module lpg_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [lpg_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic [lpg_pkg::STATUS_W-1:0]    m_tuser,
    input wire logic                            m_tlast
);
    import lpg_pkg::*;

    // reset empties the result side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a rejection is a bare last item
    a_reject_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_REJECT |-> m_tlast && m_tdata == '0)
        else $error("rejection item not blank or not last");

    // a step with no line carries nothing
    a_idle_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_IDLE |-> !m_tlast && m_tdata == '0)
        else $error("idle item not blank");

    // status carries one of the three codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_PIXEL || m_tuser == ST_REJECT || m_tuser == ST_IDLE))
        else $error("unknown status code");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind line_pixel_generator_unit lpg_checker u_lpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/line_pixel_generator_unit_tb.sv =====
// line tracer testbench: directed rows then random lines, each result checked against a predictor or a typed want
module line_pixel_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpg_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    // one directed row: a register write or an input item, optionally with a typed result
    typedef struct {
        bit                cfg_row;
        logic              cfg_idx;
        logic [DIM_W-1:0]  cfg_val;
        lpg_item_t         item;
        bit                typed;
        lpg_result_t       want;
    } probe_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [DIM_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   m_tlast;

    // expected results still owed by the block, oldest first
    lpg_result_t pixel_q[$];
    int          fail_cnt  = 0;
    int          item_cnt  = 0;
    int          quiet_cnt = 0;
    bit          idle_on   = 1'b1;

    // tracer copy: image size and line registers
    logic [DIM_W-1:0]      width_lim  = DIM_RESET;
    logic [DIM_W-1:0]      height_lim = DIM_RESET;
    logic [COORD_BITS-1:0] cur_x = '0, cur_y = '0, goal_x = '0, goal_y = '0;
    logic [COORD_BITS-1:0] step_cnt = '0;
    logic [COLOR_W-1:0]    col_r = '0, col_g = '0, col_b = '0;
    int                    dx = 0, ndy = 0, err = 0;
    bit                    x_neg = 1'b0, y_neg = 1'b0, line_on = 1'b0;

    line_pixel_generator_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // next pixel of the traced line, or a reject or idle result, for one accepted item
    function automatic lpg_result_t trace_pixel(input lpg_item_t it);
        lpg_result_t   r;
        lpg_in_data_t  d;
        int            sx, sy, ex, ey, e2;
        r  = '0;
        d  = it.data;
        sx = d.start_x;
        sy = d.start_y;
        ex = d.end_x;
        ey = d.end_y;
        if (it.action == ACT_LOAD) begin
            if (sx >= width_lim || ex >= width_lim || sy >= height_lim || ey >= height_lim) begin
                line_on  = 1'b0;
                r.status = ST_REJECT;
                r.last   = 1'b1;
                return r;
            end
            col_r    = d.red_in;
            col_g    = d.green_in;
            col_b    = d.blue_in;
            cur_x    = d.start_x;
            cur_y    = d.start_y;
            goal_x   = d.end_x;
            goal_y   = d.end_y;
            dx       = (sx < ex) ? ex - sx : sx - ex;
            ndy      = (sy < ey) ? sy - ey : ey - sy;
            x_neg    = !(sx < ex);
            y_neg    = !(sy < ey);
            err      = dx + ndy;
            step_cnt = '0;
            line_on  = !(sx == ex && sy == ey);
        end else if (!line_on) begin
            r.status = ST_IDLE;
            return r;
        end else begin
            // both tests use the error term from before this step
            e2       = err * 2;
            step_cnt = step_cnt + 1'b1;
            if (e2 >= ndy) begin
                err   = err + ndy;
                cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
            end
            if (e2 <= dx) begin
                err   = err + dx;
                cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
            end
            line_on = !(cur_x == goal_x && cur_y == goal_y);
        end
        r.status         = ST_PIXEL;
        r.last           = !line_on;
        r.data.pixel_x   = cur_x;
        r.data.pixel_y   = cur_y;
        r.data.red_out   = col_r;
        r.data.green_out = col_g;
        r.data.blue_out  = col_b;
        r.data.length    = step_cnt;
        return r;
    endfunction

    function automatic lpg_item_t make_item(input logic act, input int sx, input int sy,
                                            input int ex, input int ey, input int cr,
                                            input int cg, input int cb);
        lpg_item_t it;
        it.action        = act;
        it.data.start_x  = COORD_BITS'(sx);
        it.data.start_y  = COORD_BITS'(sy);
        it.data.end_x    = COORD_BITS'(ex);
        it.data.end_y    = COORD_BITS'(ey);
        it.data.red_in   = COLOR_W'(cr);
        it.data.green_in = COLOR_W'(cg);
        it.data.blue_in  = COLOR_W'(cb);
        return it;
    endfunction

    // step item with junk in the ignored payload
    function automatic lpg_item_t step_item();
        return make_item(ACT_STEP, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
    endfunction

    // load inside the current image size (full coordinate range when a size is zero or above 4096), mostly short lines
    function automatic lpg_item_t rand_line();
        int lx, ly, sx, sy, ex, ey;
        lx = (width_lim > DIM_RESET) ? int'(DIM_RESET) : int'(width_lim);
        ly = (height_lim > DIM_RESET) ? int'(DIM_RESET) : int'(height_lim);
        if (lx == 0) lx = int'(DIM_RESET);
        if (ly == 0) ly = int'(DIM_RESET);
        sx = $urandom_range(0, lx - 1);
        sy = $urandom_range(0, ly - 1);
        if ($urandom_range(0, 5) == 0) begin
            ex = $urandom_range(0, lx - 1);
            ey = $urandom_range(0, ly - 1);
        end else begin
            ex = sx - 16 + int'($urandom_range(0, 32));
            ey = sy - 16 + int'($urandom_range(0, 32));
            if (ex < 0) ex = 0;
            if (ey < 0) ey = 0;
            if (ex > lx - 1) ex = lx - 1;
            if (ey > ly - 1) ey = ly - 1;
        end
        return make_item(ACT_LOAD, sx, sy, ex, ey, $urandom, $urandom, $urandom);
    endfunction

    // directed row builders
    function automatic probe_row_t cfg_row(input logic idx, input int val);
        probe_row_t rw;
        rw         = '{default: '0};
        rw.cfg_row = 1'b1;
        rw.cfg_idx = idx;
        rw.cfg_val = DIM_W'(val);
        return rw;
    endfunction

    function automatic probe_row_t load_row(input int sx, input int sy, input int ex,
                                            input int ey, input int cr, input int cg,
                                            input int cb);
        probe_row_t rw;
        rw      = '{default: '0};
        rw.item = make_item(ACT_LOAD, sx, sy, ex, ey, cr, cg, cb);
        return rw;
    endfunction

    function automatic probe_row_t step_row();
        probe_row_t rw;
        rw      = '{default: '0};
        rw.item = step_item();
        return rw;
    endfunction

    function automatic probe_row_t with_want(input probe_row_t rw, input logic [STATUS_W-1:0] st,
                                             input logic lst, input int px, input int py,
                                             input int cr, input int cg, input int cb,
                                             input int len);
        rw.typed               = 1'b1;
        rw.want.status         = st;
        rw.want.last           = lst;
        rw.want.data.pixel_x   = COORD_BITS'(px);
        rw.want.data.pixel_y   = COORD_BITS'(py);
        rw.want.data.red_out   = COLOR_W'(cr);
        rw.want.data.green_out = COLOR_W'(cg);
        rw.want.data.blue_out  = COLOR_W'(cb);
        rw.want.data.length    = COORD_BITS'(len);
        return rw;
    endfunction

    // send one item, predict it once taken
    task automatic push_item(input lpg_item_t it, input bit typed, input lpg_result_t want);
        lpg_result_t pred;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= IN_TDATA_W'(it.data);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = trace_pixel(it);
        pixel_q.push_back(typed ? want : pred);
        item_cnt++;
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_lim = val;
        else height_lim = val;
    endtask

    // random lines under one image size
    task automatic run_phase(input int n, input int w, input int h);
        int  stop_at, kind, steps;
        bit  to_end;
        write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
        stop_at = item_cnt + n;
        while (item_cnt < stop_at) begin
            kind   = $urandom_range(0, 9);
            to_end = 1'b0;
            if (kind == 0) begin
                // noise: any coordinates, often out of bounds
                push_item(make_item(ACT_LOAD, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom), 1'b0, '0);
                steps = $urandom_range(0, 2);
            end else if (kind == 1) begin
                steps = $urandom_range(1, 3);
            end else begin
                push_item(rand_line(), 1'b0, '0);
                to_end = ($urandom_range(0, 3) != 0);
                steps  = to_end ? 48 : $urandom_range(0, 4);
            end
            for (int i = 0; i < steps; i++) begin
                if (to_end && !line_on) break;
                push_item(step_item(), 1'b0, '0);
            end
        end
    endtask

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // compare each taken result item with the oldest expected pixel
    always @(posedge aclk) begin : result_check
        lpg_result_t   want;
        lpg_out_data_t got;
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                $error("result item with nothing expected");
                fail_cnt++;
            end else begin
                want = pixel_q.pop_front();
                got  = m_tdata[OUT_DATA_W-1:0];
                check_field("pixel_x", want.data.pixel_x, got.pixel_x);
                check_field("pixel_y", want.data.pixel_y, got.pixel_y);
                check_field("red_out", want.data.red_out, got.red_out);
                check_field("green_out", want.data.green_out, got.green_out);
                check_field("blue_out", want.data.blue_out, got.blue_out);
                check_field("length", want.data.length, got.length);
                check_field("tdata_pad", 0, m_tdata[OUT_TDATA_W-1:OUT_DATA_W]);
                check_field("status", want.status, m_tuser);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // stimulus
    initial begin
        probe_row_t probes[$];
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_LOAD;

        // step with no line, extreme corners, point line, lines in several directions
        probes.push_back(with_want(step_row(), ST_IDLE, 1'b0, 0, 0, 0, 0, 0, 0));
        probes.push_back(with_want(load_row(0, 0, COORD_MAX, COORD_MAX, 'hff, 'h00, 'ha5),
                                   ST_PIXEL, 1'b0, 0, 0, 'hff, 'h00, 'ha5, 0));
        probes.push_back(step_row());
        probes.push_back(step_row());
        probes.push_back(with_want(load_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                            'hff, 'hff, 'hff),
                                   ST_PIXEL, 1'b1, COORD_MAX, COORD_MAX, 'hff, 'hff, 'hff, 0));
        probes.push_back(with_want(step_row(), ST_IDLE, 1'b0, 0, 0, 0, 0, 0, 0));
        probes.push_back(load_row(5, 5, 2, 8, 'h12, 'h34, 'h56));
        probes.push_back(step_row());
        probes.push_back(step_row());
        probes.push_back(step_row());
        probes.push_back(load_row(0, 7, 3, 7, 'h01, 'h80, 'h7f));
        probes.push_back(step_row());
        // reload while a line is still running
        probes.push_back(load_row(COORD_MAX, 0, COORD_MAX - 1, 3, 'h5a, 'ha5, 'h3c));
        probes.push_back(step_row());
        probes.push_back(step_row());
        probes.push_back(step_row());
        // small image: rejection on either axis
        probes.push_back(cfg_row(REG_IMAGE_WIDTH, 100));
        probes.push_back(cfg_row(REG_IMAGE_HEIGHT, 50));
        probes.push_back(with_want(load_row(100, 0, 0, 0, 'hff, 'hff, 'hff),
                                   ST_REJECT, 1'b1, 0, 0, 0, 0, 0, 0));
        probes.push_back(with_want(load_row(0, 0, 99, 50, 'hff, 'hff, 'hff),
                                   ST_REJECT, 1'b1, 0, 0, 0, 0, 0, 0));
        probes.push_back(load_row(99, 49, 0, 0, 'h11, 'h22, 'h33));
        probes.push_back(step_row());
        // size change mid-line, then zero width rejects and drops the line
        probes.push_back(cfg_row(REG_IMAGE_WIDTH, 0));
        probes.push_back(step_row());
        probes.push_back(with_want(load_row(0, 0, 0, 0, 'hff, 'hff, 'hff),
                                   ST_REJECT, 1'b1, 0, 0, 0, 0, 0, 0));
        probes.push_back(with_want(step_row(), ST_IDLE, 1'b0, 0, 0, 0, 0, 0, 0));
        // single row image
        probes.push_back(cfg_row(REG_IMAGE_WIDTH, 4096));
        probes.push_back(cfg_row(REG_IMAGE_HEIGHT, 1));
        probes.push_back(load_row(COORD_MAX, 0, 0, 0, 'h00, 'hff, 'h00));
        probes.push_back(step_row());

        // reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        foreach (probes[i]) begin
            if (probes[i].cfg_row)
                write_reg(probes[i].cfg_idx, probes[i].cfg_val);
            else
                push_item(probes[i].item, probes[i].typed, probes[i].want);
        end

        // random phases across image sizes, extremes included
        run_phase(150, 4096, 4096);
        run_phase(150, 8191, 8191);
        run_phase(150, $urandom_range(1, 4096), $urandom_range(1, 4096));
        run_phase(120, 1, 4096);
        run_phase(120, 4096, 1);
        run_phase(150, $urandom_range(2, 40), $urandom_range(2, 40));
        run_phase(40, 0, 0);
        run_phase(150, $urandom_range(1, 4096), $urandom_range(1, 4096));

        // last stretch with no idling: corner-to-edge line partly traced, then random
        write_reg(REG_IMAGE_WIDTH, DIM_RESET);
        write_reg(REG_IMAGE_HEIGHT, DIM_RESET);
        idle_on = 1'b0;
        push_item(make_item(ACT_LOAD, 0, COORD_MAX, COORD_MAX, 1000, 'hc3, 'h3c, 'h99),
                  1'b0, '0);
        for (int i = 0; i < 48 && line_on; i++) push_item(step_item(), 1'b0, '0);
        run_phase(100, 4096, 4096);

        // drain
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lpg_pkg.sv
design/lpg_in_stage.sv
design/lpg_core.sv
design/lpg_out_stage.sv
design/line_pixel_generator_unit.sv
design/lpg_checker.sv
verif/line_pixel_generator_unit_tb.sv
